FILE: rtl/rese_pkg.sv
// ----------------------------------------------------------------------------
// Rotary encoder speed events package
// Shared widths, step codes, register indexes and the state and event types.
// ----------------------------------------------------------------------------
package rese_pkg;

  localparam int unsigned PINS_W     = 2;
  localparam int unsigned QUIET_W    = 5;
  localparam int unsigned WEIGHT_W   = 5;
  localparam int unsigned ACC_W      = 8;
  localparam int unsigned ACC_SHIFT  = 5;
  localparam int unsigned SPEED_W    = ACC_W - ACC_SHIFT;
  localparam int unsigned NET_W      = 17;
  localparam int unsigned CD_W       = 17;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(50);

  // Previous pin pair in the upper two bits, new pair in the lower two.
  localparam logic [2*PINS_W-1:0] CODE_STEP_UP   = 4'he;
  localparam logic [2*PINS_W-1:0] CODE_STEP_DOWN = 4'hd;

  // Register index taken from paddr[2].
  localparam logic REG_REPORT_INTERVAL = 1'b0;

  typedef struct packed {
    logic [PINS_W-1:0]         prev_pins;
    logic [QUIET_W-1:0]        quiet;
    logic [ACC_W-1:0]          acc;
    logic signed [NET_W-1:0]   net;
    logic signed [CD_W-1:0]    countdown;
  } rese_state_t;

  typedef struct packed {
    logic               fire;
    logic               direction_up;
    logic [SPEED_W-1:0] speed;
  } rese_event_t;

endpackage

FILE: rtl/rese_step.sv
// ----------------------------------------------------------------------------
// Rotary encoder tick update
// Next-state logic for one tick: quiet timer, speed accumulator, step decode,
// net sum and report countdown, plus the event that the tick raises.
// ----------------------------------------------------------------------------
module rese_step
  import rese_pkg::*;
#(
  parameter int unsigned QUIET_LIMIT    = 24,
  parameter int unsigned WEIGHT_DIVIDER = 4
) (
  input  rese_state_t           state_i,
  input  logic [PINS_W-1:0]     pins_i,
  input  logic [INTERVAL_W-1:0] interval_i,
  output rese_state_t           state_o,
  output rese_event_t           event_o
);

  localparam logic [QUIET_W-1:0] QuietLimit = QUIET_W'(QUIET_LIMIT);

  // The weight divider is at most eight and the gap is five bits wide, so a
  // multiply by the rounded-up reciprocal and a shift gives the exact quotient.
  localparam int unsigned RecipShift = 8;
  localparam int unsigned ProdW      = QUIET_W + RecipShift;
  localparam logic [RecipShift:0] WeightRecip =
      (RecipShift+1)'(((1 << RecipShift) + WEIGHT_DIVIDER - 1) / WEIGHT_DIVIDER);

  logic [QUIET_W-1:0]     quiet_inc;
  logic [QUIET_W-1:0]     quiet_gap;
  logic [ProdW-1:0]       weight_prod;
  logic [WEIGHT_W-1:0]    weight_raw;
  logic [WEIGHT_W-1:0]    weight;
  logic [ACC_W:0]         acc_sum;
  logic [ACC_W-1:0]       acc_new;
  logic [2*PINS_W-1:0]    code;
  logic                   step_up;
  logic                   step_down;
  logic signed [NET_W:0]  net_sum;
  logic signed [NET_W-1:0] net_new;
  logic signed [CD_W-1:0] cd_new;
  logic                   fire;

  always_comb begin
    quiet_inc = (state_i.quiet >= QuietLimit) ? QuietLimit : state_i.quiet + 1'b1;
    quiet_gap = QuietLimit - quiet_inc;
    weight_prod = ProdW'(quiet_gap) * ProdW'(WeightRecip);
    weight_raw = WEIGHT_W'(weight_prod >> RecipShift);
    if (quiet_inc == QuietLimit || weight_raw == '0) begin
      weight = WEIGHT_W'(1);
    end else begin
      weight = weight_raw;
    end

    // Leaky accumulator: lose one thirty-second, gain the weight, clamp.
    acc_sum = {1'b0, state_i.acc}
            - (ACC_W+1)'(state_i.acc >> ACC_SHIFT)
            + (ACC_W+1)'(weight);
    acc_new = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];

    code      = {state_i.prev_pins, pins_i};
    step_up   = (code == CODE_STEP_UP);
    step_down = (code == CODE_STEP_DOWN);

    net_sum = {state_i.net[NET_W-1], state_i.net};
    if (step_up) begin
      net_sum = net_sum + (NET_W+1)'(1);
    end else if (step_down) begin
      net_sum = net_sum - (NET_W+1)'(1);
    end
    // Overflow of the signed sum shows as differing top bits.
    if (net_sum[NET_W] != net_sum[NET_W-1]) begin
      net_new = net_sum[NET_W] ? {1'b1, {(NET_W-1){1'b0}}} : {1'b0, {(NET_W-1){1'b1}}};
    end else begin
      net_new = net_sum[NET_W-1:0];
    end

    // The countdown stops at minus one.
    cd_new = state_i.countdown[CD_W-1] ? state_i.countdown
                                       : state_i.countdown - CD_W'(1);

    fire = cd_new[CD_W-1] && (net_new != '0);

    state_o.prev_pins = pins_i;
    state_o.quiet     = (step_up || step_down) ? '0 : quiet_inc;
    state_o.acc       = acc_new;
    state_o.net       = fire ? '0 : net_new;
    state_o.countdown = fire ? CD_W'({1'b0, interval_i}) : cd_new;

    event_o.fire         = fire;
    event_o.direction_up = ~net_new[NET_W-1];
    event_o.speed        = acc_new[ACC_W-1:ACC_SHIFT];
  end

endmodule

FILE: rtl/rotary_encoder_speed_events.sv
// ----------------------------------------------------------------------------
// Rotary encoder speed events
// Decodes detent steps from quadrature pin samples, estimates rotation speed
// and reports net direction at most once per programmable interval.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  ---------------------------
// in        sink       in_valid_i/in_ready_o  pin_a_i, pin_b_i
// out       source     out_valid_o/out_ready_i direction_up_o, speed_o
// config    APB slave  psel/penable/pready    paddr, pwdata, prdata
//
// One input transaction can be accepted in every cycle while the input
// register is free or being emptied. An accepted tick waits in the input
// register until the single-pass update logic runs; that logic writes the
// state and, when the tick raises an event, the output register.
// A waiting result stalls only the input register; the input side keeps
// taking transactions until that register is also full.
// Reset clears the decoder state, loads the report interval with 50 and
// leaves both channels empty. Ticks that raise no event produce no output
// transaction. The report interval is written at byte address 0; the user
// must write it only while the block is idle, which the block does not enforce.
//
module rotary_encoder_speed_events
  import rese_pkg::*;
#(
  parameter int unsigned QUIET_LIMIT    = 24,
  parameter int unsigned WEIGHT_DIVIDER = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Tick input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  pin_a_i,
  input  logic                  pin_b_i,
  // Event output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  direction_up_o,
  output logic [SPEED_W-1:0]    speed_o,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Configuration register. paddr[2] selects the register word; the only
  // register lives at word zero, anything else is ignored on write and
  // reads back as zero.
  logic [INTERVAL_W-1:0] interval_q;
  logic                  cfg_write;
  logic                  reg_sel;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready
                     && (reg_sel == REG_REPORT_INTERVAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= INTERVAL_RESET;
    end else if (cfg_write) begin
      interval_q <= pwdata[INTERVAL_W-1:0];
    end
  end

  always_comb begin
    case (reg_sel)
      REG_REPORT_INTERVAL: prdata = APB_DATA_W'(interval_q);
      default:             prdata = '0;
    endcase
  end

  // Input register: holds one accepted tick until the update stage can run.
  logic              s1_valid_q;
  logic              s1_valid_d;
  logic [PINS_W-1:0] s1_pins_q;
  logic              advance;
  logic              in_accept;

  // The update runs whenever a tick waits and the output register is free
  // or being emptied in this cycle.
  assign advance    = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pins_q <= {pin_a_i, pin_b_i};
    end
  end

  // Decoder state and its single-pass update.
  rese_state_t state_q;
  rese_state_t state_d;
  rese_event_t tick_event;

  rese_step #(
    .QUIET_LIMIT    (QUIET_LIMIT),
    .WEIGHT_DIVIDER (WEIGHT_DIVIDER)
  ) u_step (
    .state_i    (state_q),
    .pins_i     (s1_pins_q),
    .interval_i (interval_q),
    .state_o    (state_d),
    .event_o    (tick_event)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output register. A new event may replace one that is taken in the same
  // cycle, so back-to-back events flow without a gap.
  logic               out_valid_q;
  logic               out_valid_d;
  logic               dir_q;
  logic [SPEED_W-1:0] speed_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = tick_event.fire;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && tick_event.fire) begin
      dir_q   <= tick_event.direction_up;
      speed_q <= tick_event.speed;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign direction_up_o = dir_q;
  assign speed_o        = speed_q;

endmodule

FILE: rtl/rese_checker.sv
// ----------------------------------------------------------------------------
// Rotary encoder speed events checker
// Port-level properties of the block, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rese_sva_checker
  import rese_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               direction_up_o,
  input logic [SPEED_W-1:0] speed_o,
  input logic               pready
);

  // A pending event holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(direction_up_o)
                                    && $stable(speed_o))
    else $error("event changed or dropped while stalled");

  // The configuration port never inserts wait states.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready deasserted");

  // The input side only stalls behind a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // A fresh event comes from an accepted tick that has passed through the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("event without a matching tick");

endmodule

bind rotary_encoder_speed_events rese_sva_checker u_rese_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .direction_up_o (direction_up_o),
  .speed_o        (speed_o),
  .pready         (pready)
);

FILE: tb/sv/rese_checker.sv
// ----------------------------------------------------------------------------
// Rotary encoder speed events checker
// Watches the tick, event and configuration ports, predicts every event from
// the accepted ticks and compares each delivered event field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rese_checker
  import rese_pkg::*;
#(
  parameter int unsigned QUIET_LIMIT    = 24,
  parameter int unsigned WEIGHT_DIVIDER = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tick_valid_i,
  input  logic                  tick_ready_i,
  input  logic                  pin_a_i,
  input  logic                  pin_b_i,
  input  logic                  event_valid_i,
  input  logic                  event_ready_i,
  input  logic                  direction_up_i,
  input  logic [SPEED_W-1:0]    speed_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  input  logic [APB_DATA_W-1:0] prdata_i,
  input  logic                  pready_i,
  output int                    mismatches_o,
  output int                    reports_owed_o,
  output int                    reports_checked_o
);

  localparam int unsigned ACC_MAX = (1 << ACC_W) - 1;
  localparam int          NET_MAX = (1 << (NET_W - 1)) - 1;
  localparam int          NET_MIN = -(1 << (NET_W - 1));

  rese_state_t             encoder;
  logic [INTERVAL_W-1:0]   interval_q;
  rese_event_t             report_backlog[$];

  // One tick of the encoder: updates the local state copy and returns the
  // report the tick raises, with fire low when it raises none.
  function automatic rese_event_t advance_tick(input logic [PINS_W-1:0] pins);
    int unsigned      quiet_n;
    int unsigned      weight;
    int unsigned      acc_n;
    int               net_n;
    int               cd_n;
    int               step;
    logic [2*PINS_W-1:0] code;
    rese_event_t      report;
    quiet_n = encoder.quiet + 1;
    if (quiet_n > QUIET_LIMIT) quiet_n = QUIET_LIMIT;
    if (quiet_n >= QUIET_LIMIT) weight = 1;
    else weight = (QUIET_LIMIT - quiet_n) / WEIGHT_DIVIDER;
    if (weight == 0) weight = 1;

    acc_n = encoder.acc - (encoder.acc >> ACC_SHIFT) + weight;
    if (acc_n > ACC_MAX) acc_n = ACC_MAX;

    code = {encoder.prev_pins, pins};
    if (code == CODE_STEP_UP) step = 1;
    else if (code == CODE_STEP_DOWN) step = -1;
    else step = 0;
    if (step != 0) quiet_n = 0;

    net_n = encoder.net;
    net_n = net_n + step;
    if (net_n > NET_MAX) net_n = NET_MAX;
    if (net_n < NET_MIN) net_n = NET_MIN;

    // The countdown parks at -1 once it has expired.
    cd_n = encoder.countdown;
    if (cd_n > -1) cd_n = cd_n - 1;

    report = '0;
    if (cd_n < 0 && net_n != 0) begin
      report.fire         = 1'b1;
      report.direction_up = (net_n > 0);
      report.speed        = SPEED_W'(acc_n >> ACC_SHIFT);
      cd_n                = int'(interval_q);
      net_n               = 0;
    end

    encoder.prev_pins = pins;
    encoder.quiet     = QUIET_W'(quiet_n);
    encoder.acc       = ACC_W'(acc_n);
    encoder.net       = NET_W'(net_n);
    encoder.countdown = CD_W'(cd_n);
    return report;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rese_event_t due;
    rese_event_t raised;
    if (!rst_ni) begin
      encoder           = '0;
      interval_q        = INTERVAL_RESET;
      report_backlog.delete();
      mismatches_o      = 0;
      reports_owed_o    = 0;
      reports_checked_o = 0;
    end else begin
      // A delivered event always belongs to a tick accepted at an earlier
      // edge, so it is checked before this edge's tick is predicted.
      if (event_valid_i && event_ready_i) begin
        if (report_backlog.size() == 0) begin
          $error("event with none expected: direction_up %0d speed %0d",
                 direction_up_i, speed_i);
          mismatches_o++;
        end else begin
          due = report_backlog.pop_front();
          if (direction_up_i !== due.direction_up) begin
            $error("direction_up: expected %0d, actual %0d",
                   due.direction_up, direction_up_i);
            mismatches_o++;
          end
          if (speed_i !== due.speed) begin
            $error("speed: expected %0d, actual %0d", due.speed, speed_i);
            mismatches_o++;
          end
          reports_checked_o++;
        end
      end

      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i[2] == REG_REPORT_INTERVAL) interval_q = pwdata_i[INTERVAL_W-1:0];
        end else if (paddr_i[2] == REG_REPORT_INTERVAL) begin
          if (prdata_i !== APB_DATA_W'(interval_q)) begin
            $error("report_interval: expected %0d, actual %0d", interval_q, prdata_i);
            mismatches_o++;
          end
        end
      end

      if (tick_valid_i && tick_ready_i) begin
        raised = advance_tick({pin_a_i, pin_b_i});
        if (raised.fire) report_backlog.push_back(raised);
      end
      reports_owed_o = report_backlog.size();
    end
  end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Rotary encoder speed events testbench
// Drives pin samples, interval writes and backpressure into the encoder block
// and lets the checker predict and compare every direction event it reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import rese_pkg::*;
;

  localparam int unsigned QUIET_LIMIT    = 24;
  localparam int unsigned WEIGHT_DIVIDER = 4;

  // Drain time after the last predicted event, so that any tick still in the
  // pipe that raises nothing has left it.
  localparam int DRAIN_CYCLES = 6;
  // Cycles without a single transaction on any port before the run is abandoned.
  localparam int STALL_LIMIT  = 1000;
  localparam int PHASES       = 8;
  localparam int PHASE_TICKS  = 115;

  localparam logic [APB_ADDR_W-1:0] INTERVAL_ADDR = {REG_REPORT_INTERVAL, 2'b00};
  // The next word up maps to no register; writes there must be dropped.
  localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR   = 3'h4;

  // Pin pairs {a, b} of one detent, starting from the rest position 11.
  localparam logic [1:0] PINS_REST = 2'b11;
  localparam logic [7:0] DETENT_UP   = {2'b11, 2'b10, 2'b00, 2'b01};
  localparam logic [7:0] DETENT_DOWN = {2'b11, 2'b01, 2'b00, 2'b10};

  // A walk through all sixteen pin pair transitions, each taken once.
  localparam int          WALK_LEN  = 17;
  localparam logic [33:0] PAIR_WALK = {2'd0, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1,
                                       2'd1, 2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3,
                                       2'd0};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  pin_a_i;
  logic                  pin_b_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  direction_up_o;
  logic [SPEED_W-1:0]    speed_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches;
  int reports_owed;
  int reports_checked;

  // Percent chance, per cycle, that the sender holds back or the receiver
  // stalls. Each phase picks its own pair.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          ticks_sent;
  int          idle_cycles;
  // Ticks beyond this count are dropped, so a phase stops at its budget even
  // in the middle of a burst.
  int          tick_cap;

  rotary_encoder_speed_events #(
    .QUIET_LIMIT   (QUIET_LIMIT),
    .WEIGHT_DIVIDER(WEIGHT_DIVIDER)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pin_a_i       (pin_a_i),
    .pin_b_i       (pin_b_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .direction_up_o(direction_up_o),
    .speed_o       (speed_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  rese_checker #(
    .QUIET_LIMIT   (QUIET_LIMIT),
    .WEIGHT_DIVIDER(WEIGHT_DIVIDER)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tick_valid_i     (in_valid_i),
    .tick_ready_i     (in_ready_o),
    .pin_a_i          (pin_a_i),
    .pin_b_i          (pin_b_i),
    .event_valid_i    (out_valid_o),
    .event_ready_i    (out_ready_i),
    .direction_up_i   (direction_up_o),
    .speed_i          (speed_o),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .prdata_i         (prdata),
    .pready_i         (pready),
    .mismatches_o     (mismatches),
    .reports_owed_o   (reports_owed),
    .reports_checked_o(reports_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The receiver decides on every falling edge whether it takes an event in
  // the next cycle, so stalls land on every phase of the block's pipeline.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: any accepted transaction on the tick, event or configuration
  // port restarts the count. The run ends here only if the block hangs.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (psel && penable && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: done, errors");
    $finish;
  end

  // Every task below is entered on a falling edge and leaves on one without
  // having driven anything there, so two tasks never drive the same signal in
  // one time step.
  task automatic send_tick(input logic [1:0] pins);
    if (ticks_sent >= tick_cap) return;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pin_a_i    <= pins[1];
    pin_b_i    <= pins[0];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    ticks_sent++;
  endtask

  task automatic apb_access(input logic write, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold the sender off until every predicted event has been delivered, then
  // give ticks that raise nothing time to leave the pipeline. Only after this
  // is the block idle enough for an interval write.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (reports_owed != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // A burst of whole detents in one direction. Every pin pair is held for a
  // random number of ticks up to dwell_cap, which sets the rotation speed:
  // a cap of one spins as fast as the pins allow, a large cap lets the quiet
  // counter run into its limit between steps.
  task automatic turn_detents(input int count, input logic up, input int dwell_cap);
    logic [7:0] detent;
    detent = up ? DETENT_UP : DETENT_DOWN;
    repeat (count) begin
      for (int k = 3; k >= 0; k--) begin
        repeat ($urandom_range(1, dwell_cap)) send_tick(detent[2*k +: 2]);
      end
    end
    send_tick(PINS_REST);
  endtask

  task automatic random_phase_traffic(input int budget);
    int start;
    int pick;
    int dwell_cap;
    start = ticks_sent;
    tick_cap = start + budget;
    while (ticks_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: dwell_cap = 1;
        1: dwell_cap = 3;
        2: dwell_cap = 12;
        default: dwell_cap = 30;
      endcase
      if (pick < 70) begin
        // Mostly clean rotation, so steps, speed and events all get exercised.
        turn_detents($urandom_range(1, 6), 1'($urandom_range(0, 1)), dwell_cap);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 8)) send_tick(2'($urandom_range(0, 3)));
      end else begin
        // Contact bounce: leave the rest position and fall straight back.
        send_tick(PINS_REST);
        send_tick(2'($urandom_range(0, 3)));
        send_tick(PINS_REST);
      end
    end
  endtask

  initial begin
    int unsigned phase_interval;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    pin_a_i        = 1'b0;
    pin_b_i        = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    ticks_sent     = 0;
    tick_cap       = 1 << 30;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The interval must read back at its reset value, and a write to the
    // unmapped word must leave it alone.
    apb_access(1'b0, INTERVAL_ADDR, '0);
    apb_access(1'b1, UNUSED_ADDR, APB_DATA_W'($urandom()));
    apb_access(1'b0, INTERVAL_ADDR, '0);

    // Directed part at a zero interval, so an event may follow every step.
    // First every pin pair transition once, then the fastest possible spin
    // upward ending in one step down.
    apb_access(1'b1, INTERVAL_ADDR, '0);
    for (int i = 0; i < WALK_LEN; i++) send_tick(PAIR_WALK[33-2*i -: 2]);
    repeat (3) begin
      send_tick(2'b11);
      send_tick(2'b10);
    end
    send_tick(2'b11);
    send_tick(2'b01);

    // Random part in phases. Each phase sets its own interval and idling
    // pattern. The largest interval comes last because once loaded into the
    // countdown it would silence the phases after it.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: phase_interval = 0;
        1: phase_interval = 5;
        2: phase_interval = 1;
        3: phase_interval = int'(INTERVAL_RESET);
        4: phase_interval = $urandom_range(3, 40);
        5: phase_interval = 0;
        6: phase_interval = 2;
        default: phase_interval = (1 << INTERVAL_W) - 1;
      endcase
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct  = 29;
          recv_stall_pct = 29;
        end
      endcase
      apb_access(1'b1, INTERVAL_ADDR, APB_DATA_W'(phase_interval));
      apb_access(1'b0, INTERVAL_ADDR, '0);
      random_phase_traffic(PHASE_TICKS);
    end

    settle();
    $display("tb: %0d ticks over %0d phases, intervals 0 to %0d, with and without idling",
             ticks_sent, PHASES + 1, (1 << INTERVAL_W) - 1);
    $display("tb: %0d direction events compared", reports_checked);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
